>>> rtl/apc_pkg.sv
// Shared constants, register codes and types for the arm position PD controller.
package apc_pkg;

    localparam int POS_WIDTH_DEF = 24;

    localparam int GAIN_W     = 20;
    localparam int LIMIT_W    = 8;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CMD_W      = 2;
    localparam int DRIVE_W    = 8;
    localparam int FRAC_BITS  = 16;
    localparam int DRIVE_MAX  = 127;

    localparam logic [GAIN_W-1:0]  P_GAIN_RST       = 20'd2058;
    localparam logic [GAIN_W-1:0]  D_GAIN_RST       = 20'd13107;
    localparam logic [LIMIT_W-1:0] SETTLE_LIMIT_RST = 8'd50;

    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_D_GAIN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LIMIT = 2'd2;

    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRIVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BRAKE = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0]  p_gain;
        logic [GAIN_W-1:0]  d_gain;
        logic [LIMIT_W-1:0] settle_limit;
    } cfg_t;

endpackage

>>> rtl/apc_if.sv
// Valid/ready channel interfaces for controller ticks and results.
interface apc_item_if #(
    parameter int POS_WIDTH = apc_pkg::POS_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] target_pos;
    logic signed [POS_WIDTH-1:0] measured_pos;
    logic                        manual_override;

    modport source (
        output valid, target_pos, measured_pos, manual_override,
        input  ready
    );
    modport sink (
        input  valid, target_pos, measured_pos, manual_override,
        output ready
    );
endinterface

interface apc_result_if;
    logic                               valid;
    logic                               ready;
    logic [apc_pkg::CMD_W-1:0]          command;
    logic signed [apc_pkg::DRIVE_W-1:0] drive;

    modport source (
        output valid, command, drive,
        input  ready
    );
    modport sink (
        input  valid, command, drive,
        output ready
    );
endinterface

>>> rtl/apc_cfg_regs.sv
// Gain and settle-limit configuration registers.
module apc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [apc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [apc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output apc_pkg::cfg_t                    cfg
);

    apc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.p_gain       <= apc_pkg::P_GAIN_RST;
            cfg_reg.d_gain       <= apc_pkg::D_GAIN_RST;
            cfg_reg.settle_limit <= apc_pkg::SETTLE_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                apc_pkg::REG_P_GAIN:
                    cfg_reg.p_gain <= cfg_wdata[apc_pkg::GAIN_W-1:0];
                apc_pkg::REG_D_GAIN:
                    cfg_reg.d_gain <= cfg_wdata[apc_pkg::GAIN_W-1:0];
                apc_pkg::REG_SETTLE_LIMIT:
                    cfg_reg.settle_limit <= cfg_wdata[apc_pkg::LIMIT_W-1:0];
                default:
                    ; // unmapped index: drop the write
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/apc_update.sv
// Error, settle tracking and gain products; holds the controller state.
module apc_update #(
    parameter int POS_WIDTH = apc_pkg::POS_WIDTH_DEF,
    localparam int ERR_W  = POS_WIDTH + 1,
    localparam int DIFF_W = POS_WIDTH + 2,
    localparam int PROD_W = apc_pkg::GAIN_W + 1 + DIFF_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic signed [POS_WIDTH-1:0]    target_pos,
    input  logic signed [POS_WIDTH-1:0]    measured_pos,
    input  logic                           manual_override,
    input  apc_pkg::cfg_t                  cfg,
    output logic signed [PROD_W-1:0]       prod_p,
    output logic signed [PROD_W-1:0]       prod_d,
    output logic [apc_pkg::CMD_W-1:0]      command
);

    localparam int GS_W = apc_pkg::GAIN_W + 1;

    // controller state
    logic signed [POS_WIDTH-1:0]      last_target_reg;
    logic signed [ERR_W-1:0]          cross_ref_reg;
    logic signed [ERR_W-1:0]          deriv_prev_reg;
    logic [apc_pkg::LIMIT_W-1:0]      settle_count_reg;
    logic                             crossed_reg;

    logic signed [ERR_W-1:0]          cross_ref_next;
    logic [apc_pkg::LIMIT_W-1:0]      settle_count_next;
    logic                             crossed_next;

    logic signed [ERR_W-1:0]          err;
    logic signed [DIFF_W-1:0]         diff;
    logic signed [GS_W-1:0]           p_s;
    logic signed [GS_W-1:0]           d_s;
    logic                             restart;
    logic [apc_pkg::LIMIT_W-1:0]      count0;
    logic signed [ERR_W-1:0]          ref0;
    logic                             crossed0;
    logic                             sign_flip;

    always_comb
    begin
        err  = ERR_W'(target_pos) - ERR_W'(measured_pos);
        diff = DIFF_W'(err) - DIFF_W'(deriv_prev_reg);
        p_s  = $signed({1'b0, cfg.p_gain});
        d_s  = $signed({1'b0, cfg.d_gain});

        prod_p = PROD_W'(p_s) * PROD_W'(err);
        prod_d = PROD_W'(d_s) * PROD_W'(diff);

        // new target or override restarts the settle tracking
        restart  = (target_pos != last_target_reg) || manual_override;
        count0   = restart ? '0 : settle_count_reg;
        ref0     = restart ? err : cross_ref_reg;
        crossed0 = restart ? 1'b0 : crossed_reg;

        sign_flip = (err[ERR_W-1] && !ref0[ERR_W-1] && (ref0 != '0))
                 || (!err[ERR_W-1] && (err != '0) && ref0[ERR_W-1]);

        cross_ref_next = err;
        if (count0 < cfg.settle_limit)
        begin
            command           = manual_override ? apc_pkg::CMD_NONE : apc_pkg::CMD_DRIVE;
            crossed_next      = crossed0 || sign_flip;
            settle_count_next = crossed_next ? count0 + 1'b1 : count0;
        end
        else
        begin
            command           = manual_override ? apc_pkg::CMD_NONE : apc_pkg::CMD_BRAKE;
            crossed_next      = 1'b0;
            settle_count_next = count0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_target_reg  <= '0;
            cross_ref_reg    <= '0;
            deriv_prev_reg   <= '0;
            settle_count_reg <= '0;
            crossed_reg      <= 1'b0;
        end
        else if (load)
        begin
            last_target_reg  <= target_pos;
            cross_ref_reg    <= cross_ref_next;
            deriv_prev_reg   <= err;
            settle_count_reg <= settle_count_next;
            crossed_reg      <= crossed_next;
        end
    end

endmodule

>>> rtl/apc_drive_out.sv
// Sum of gain products, truncation toward zero, saturation and result register.
module apc_drive_out #(
    parameter int POS_WIDTH = apc_pkg::POS_WIDTH_DEF,
    localparam int PROD_W = apc_pkg::GAIN_W + 1 + POS_WIDTH + 2
) (
    input  logic                               clk,
    input  logic                               load,
    input  logic signed [PROD_W-1:0]           prod_p,
    input  logic signed [PROD_W-1:0]           prod_d,
    input  logic [apc_pkg::CMD_W-1:0]          command_in,
    output logic [apc_pkg::CMD_W-1:0]          command,
    output logic signed [apc_pkg::DRIVE_W-1:0] drive
);

    localparam int SUM_W = PROD_W + 1;
    localparam int Q_W   = SUM_W - apc_pkg::FRAC_BITS;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(apc_pkg::DRIVE_MAX);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX;

    logic signed [SUM_W-1:0]           sum;
    logic signed [Q_W-1:0]             q_floor;
    logic signed [Q_W-1:0]             q_trunc;
    logic signed [apc_pkg::DRIVE_W-1:0] sat;
    logic signed [apc_pkg::DRIVE_W-1:0] drive_next;
    logic signed [apc_pkg::DRIVE_W-1:0] drive_reg;
    logic [apc_pkg::CMD_W-1:0]         command_reg;

    always_comb
    begin
        sum     = SUM_W'(prod_p) + SUM_W'(prod_d);
        q_floor = sum[SUM_W-1:apc_pkg::FRAC_BITS];
        // shift floors; step negative values with a fraction back toward zero
        if (sum[SUM_W-1] && (sum[apc_pkg::FRAC_BITS-1:0] != '0))
            q_trunc = q_floor + 1'b1;
        else
            q_trunc = q_floor;

        if (q_trunc > Q_MAX)
            sat = apc_pkg::DRIVE_W'(apc_pkg::DRIVE_MAX);
        else if (q_trunc < Q_MIN)
            sat = -apc_pkg::DRIVE_W'(apc_pkg::DRIVE_MAX);
        else
            sat = q_trunc[apc_pkg::DRIVE_W-1:0];

        drive_next = (command_in == apc_pkg::CMD_DRIVE) ? sat : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg   <= drive_next;
            command_reg <= command_in;
        end
    end

    assign drive   = drive_reg;
    assign command = command_reg;

endmodule

>>> rtl/arm_position_pd_controller_core.sv
// Arm position PD controller: top level with input register and result handshake.
// Takes one tick (target, measured position, override flag) per clock unless stalled
// and returns one result (command, drive) per tick, in order. A transferred tick is
// held in the input register, which feeds the error, settle tracking and the
// two gain multiplies (21 x up to POS_WIDTH+2 bits, in parallel), then the sum,
// truncation toward zero and saturation, all in one pass ahead of the result register.
// The settle and derivative state closes its loop in the same pass, so throughput is
// one tick per cycle unless the result register is stalled; the input register then
// holds its tick, and the input keeps accepting as long as either register has room.
// Configuration writes take effect on the next edge; write only while idle.
module arm_position_pd_controller_core #(
    parameter int POS_WIDTH = apc_pkg::POS_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [apc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    apc_item_if.sink                       item,
    apc_result_if.source                   result
);

    localparam int PROD_W = apc_pkg::GAIN_W + 1 + POS_WIDTH + 2;

    apc_pkg::cfg_t                 cfg;

    logic                          a_vld_reg;
    logic                          c_vld_reg;
    logic                          a_rdy;
    logic                          c_rdy;
    logic                          c_load;

    logic signed [POS_WIDTH-1:0]   target_reg;
    logic signed [POS_WIDTH-1:0]   measured_reg;
    logic                          override_reg;

    logic signed [PROD_W-1:0]      prod_p;
    logic signed [PROD_W-1:0]      prod_d;
    logic [apc_pkg::CMD_W-1:0]     upd_command;

    assign c_rdy  = !c_vld_reg || result.ready;
    assign a_rdy  = !a_vld_reg || c_rdy;
    assign c_load = c_rdy && a_vld_reg;

    assign item.ready   = a_rdy;
    assign result.valid = c_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
                a_vld_reg <= item.valid;
            if (c_rdy)
                c_vld_reg <= a_vld_reg;
        end
    end

    // capture the tick on transfer
    always_ff @(posedge clk)
    begin
        if (a_rdy && item.valid)
        begin
            target_reg   <= item.target_pos;
            measured_reg <= item.measured_pos;
            override_reg <= item.manual_override;
        end
    end

    apc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    apc_update #(
        .POS_WIDTH (POS_WIDTH)
    ) u_update (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (c_load),
        .target_pos      (target_reg),
        .measured_pos    (measured_reg),
        .manual_override (override_reg),
        .cfg             (cfg),
        .prod_p          (prod_p),
        .prod_d          (prod_d),
        .command         (upd_command)
    );

    apc_drive_out #(
        .POS_WIDTH (POS_WIDTH)
    ) u_drive_out (
        .clk        (clk),
        .load       (c_load),
        .prod_p     (prod_p),
        .prod_d     (prod_d),
        .command_in (upd_command),
        .command    (result.command),
        .drive      (result.drive)
    );

endmodule
